// File: sv/ihexw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record writer package
// Field widths, control word layout, microcode addresses and the hex digit
// helper shared by the writer, its microcode table and its interfaces.
// ----------------------------------------------------------------------------
package ihexw_pkg;

  localparam int OP_W    = 1;
  localparam int DATA_W  = 8;
  localparam int ADDR_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int RLEN_W  = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_END   = 1'b1;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_RECORD_LENGTH = 1'b0;
  localparam logic [RLEN_W-1:0] RLEN_RESET = 5'd16;

  // Microcode.
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_REC  = 5'd0;
  localparam logic [PC_W-1:0] PC_DATA = 5'd9;
  localparam logic [PC_W-1:0] PC_EOF  = 5'd14;
  localparam logic [PC_W-1:0] PC_ERR  = 5'd26;

  localparam logic [2:0] SRC_CONST   = 3'd0;
  localparam logic [2:0] SRC_COUNT   = 3'd1;
  localparam logic [2:0] SRC_ADDR_HI = 3'd2;
  localparam logic [2:0] SRC_ADDR_LO = 3'd3;
  localparam logic [2:0] SRC_DATA    = 3'd4;
  localparam logic [2:0] SRC_SUM     = 3'd5;

  localparam logic [1:0] FL_NEXT    = 2'd0;
  localparam logic [1:0] FL_DATA    = 2'd1;
  localparam logic [1:0] FL_REC_END = 2'd2;
  localparam logic [1:0] FL_DONE    = 2'd3;

  typedef struct packed {
    logic [2:0]        src;
    logic              hi_nib;
    logic [CHAR_W-1:0] chr;
    logic              err;
    logic [1:0]        flow;
  } ctrl_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] base;
    base = (nib < 4'd10) ? 8'h30 : 8'h37;
    return base + CHAR_W'(nib);
  endfunction

endpackage

// File: sv/ihexw_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Carries one write-byte or end command per transaction.
// ----------------------------------------------------------------------------
interface ihexw_cmd_if;
  import ihexw_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] data_byte;
  logic [ADDR_W-1:0] byte_address;

  modport source(output valid, op, data_byte, byte_address, input ready);
  modport sink(input valid, op, data_byte, byte_address, output ready);
endinterface

// File: sv/ihexw_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Carries one ASCII character of hex text per transaction.
// ----------------------------------------------------------------------------
interface ihexw_char_if;
  import ihexw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last_char;
  logic              address_error;

  modport source(output valid, ascii_char, last_char, address_error, input ready);
  modport sink(input valid, ascii_char, last_char, address_error, output ready);
endinterface

// File: sv/intel_hex_record_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record writer
// Gathers addressed bytes into a line buffer and writes Intel HEX data and
// end-of-file records as a stream of ASCII characters.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Carries
//   -------  ---------  ------------------------------------------------------
//   cmd      in         op, data_byte, byte_address (write byte or end)
//   chars    out        ascii_char, last_char, address_error
//   APB      in/out     record_length at byte addresses 0 to 3
//
// A command that causes no characters is absorbed in its accept cycle. One
// that causes characters occupies the sequencer for one step per character,
// starting after the accept: a data record of n bytes is 12 + 2n
// steps, the end-of-file record 12 more, an address error a single step.
// Steps advance only while the output register is empty or being emptied,
// so a stalled sink simply freezes the sequencer. cmd.ready is low while
// the sequencer runs. Reset is synchronous; the line buffer itself is not
// cleared, since only filled entries are ever read.
// ----------------------------------------------------------------------------
module intel_hex_record_writer #(
  parameter int LINE_BYTES    = 16,
  parameter int ADDRESS_LIMIT = 16384
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ihexw_pkg::PADDR_W-1:0] paddr,
  input  logic [ihexw_pkg::PDATA_W-1:0] pwdata,
  output logic [ihexw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  ihexw_cmd_if.sink                    cmd,
  ihexw_char_if.source                 chars
);
  import ihexw_pkg::*;

  // Widths that follow from the parameters.
  localparam int CW   = $clog2(LINE_BYTES + 1);              // line byte count
  localparam int IW   = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int SW   = $clog2(ADDRESS_LIMIT);               // stored address
  localparam int AXW  = ADDR_W + 1;                          // address compares
  localparam int LW   = (CW > RLEN_W) ? CW : RLEN_W;         // length compares

  // Configuration.
  logic [RLEN_W-1:0] record_length;
  logic              cfg_write;

  // Line state.
  logic [DATA_W-1:0] line_buf [LINE_BYTES];
  logic [CW-1:0]     line_count;
  logic [SW-1:0]     line_start;
  logic [SW-1:0]     prev_addr;
  logic              prev_valid;

  // Command held while its characters are produced.
  logic              item_op;
  logic [DATA_W-1:0] item_data;
  logic [SW-1:0]     item_addr;

  // Sequencer.
  logic              busy;
  logic [PC_W-1:0]   pc;
  logic [IW-1:0]     idx;
  logic [7:0]        sum;
  ctrl_t             ctrl;
  logic              step;
  logic              accept;

  // Decode of the incoming command.
  logic [AXW-1:0]    addr_x;
  logic [AXW-1:0]    prev_next_x;
  logic              addr_bad;
  logic [LW-1:0]     eff_limit;
  logic [LW-1:0]     rlen_x;
  logic              new_line;
  logic [ADDR_W-1:0] start16;
  logic [7:0]        sum_init;

  // Character datapath.
  logic [7:0]        src_byte;
  logic [CHAR_W-1:0] char_val;
  logic              char_last;

  // ---------------------------------------------------------------- APB --
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[PADDR_W-1:2] == REG_RECORD_LENGTH);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_RECORD_LENGTH)
                     ? PDATA_W'(record_length) : '0;

  // ------------------------------------------------------------- decode --
  // A record length of zero acts as one; values beyond the buffer clamp.
  assign rlen_x    = LW'(record_length);
  assign eff_limit = (rlen_x == '0) ? LW'(1)
                   : (rlen_x > LW'(LINE_BYTES)) ? LW'(LINE_BYTES) : rlen_x;

  assign addr_x      = {1'b0, cmd.byte_address};
  assign prev_next_x = AXW'(prev_addr) + AXW'(1);
  assign addr_bad    = addr_x >= AXW'(ADDRESS_LIMIT);

  // A byte opens a new line after an end or reset, after a gap in the
  // addresses, or when the buffer already holds a full record.
  assign new_line = !prev_valid || (addr_x != prev_next_x)
                    || (LW'(line_count) >= eff_limit);

  // The checksum starts from the header bytes; data bytes add in as sent.
  assign start16  = ADDR_W'(line_start);
  assign sum_init = 8'(line_count) + start16[15:8] + start16[7:0];

  assign cmd.ready = !busy;
  assign accept    = cmd.valid && !busy;

  // ----------------------------------------------------------- sequencer --
  ihexw_ucode_rom u_rom (
    .pc   (pc),
    .word (ctrl)
  );

  // A step runs whenever the output register can take its character.
  assign step = busy && (!chars.valid || chars.ready);

  always_comb begin
    case (ctrl.src)
      SRC_COUNT:   src_byte = 8'(line_count);
      SRC_ADDR_HI: src_byte = start16[15:8];
      SRC_ADDR_LO: src_byte = start16[7:0];
      SRC_DATA:    src_byte = line_buf[idx];
      SRC_SUM:     src_byte = 8'd0 - sum;
      default:     src_byte = 8'd0;
    endcase
  end

  assign char_val  = (ctrl.src == SRC_CONST) ? ctrl.chr
                   : hex_char(ctrl.hi_nib ? src_byte[7:4] : src_byte[3:0]);
  assign char_last = (ctrl.flow == FL_DONE)
                     || ((ctrl.flow == FL_REC_END) && (item_op == OP_WRITE));

  always_ff @(posedge clk) begin
    if (rst) begin
      record_length <= RLEN_RESET;
      line_count    <= '0;
      line_start    <= '0;
      prev_addr     <= '0;
      prev_valid    <= 1'b0;
      busy          <= 1'b0;
      pc            <= PC_REC;
      idx           <= '0;
    end else begin
      if (cfg_write) begin
        record_length <= pwdata[RLEN_W-1:0];
      end

      if (accept) begin
        idx <= '0;
        if (cmd.op == OP_WRITE) begin
          if (addr_bad) begin
            // The byte is dropped; only the error marker goes out.
            busy <= 1'b1;
            pc   <= PC_ERR;
          end else begin
            prev_addr  <= cmd.byte_address[SW-1:0];
            prev_valid <= 1'b1;
            if (new_line && (line_count != '0)) begin
              // Flush first; the byte is stored when the record ends.
              busy <= 1'b1;
              pc   <= PC_REC;
            end else begin
              if (new_line) begin
                line_start <= cmd.byte_address[SW-1:0];
              end
              line_count <= line_count + CW'(1);
            end
          end
        end else begin
          prev_valid <= 1'b0;
          busy       <= 1'b1;
          pc         <= (line_count != '0) ? PC_REC : PC_EOF;
        end
      end else if (step) begin
        case (ctrl.flow)
          FL_NEXT: begin
            pc <= pc + PC_W'(1);
          end
          FL_DATA: begin
            if ((CW'(idx) + CW'(1)) == line_count) begin
              pc <= pc + PC_W'(1);
            end else begin
              pc  <= PC_DATA;
              idx <= idx + IW'(1);
            end
          end
          FL_REC_END: begin
            if (item_op == OP_END) begin
              line_count <= '0;
              pc         <= PC_EOF;
            end else begin
              // The pending byte opens the new line.
              line_count <= CW'(1);
              line_start <= item_addr;
              busy       <= 1'b0;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  // Payload registers: command hold, checksum and the line buffer.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= cmd.op;
      item_data <= cmd.data_byte;
      item_addr <= cmd.byte_address[SW-1:0];
      sum       <= sum_init;
      if ((cmd.op == OP_WRITE) && !addr_bad && !(new_line && (line_count != '0))) begin
        line_buf[line_count[IW-1:0]] <= cmd.data_byte;
      end
    end else if (step) begin
      if (ctrl.flow == FL_DATA) begin
        sum <= sum + line_buf[idx];
      end
      if ((ctrl.flow == FL_REC_END) && (item_op == OP_WRITE)) begin
        line_buf[0] <= item_data;
      end
    end
  end

  // -------------------------------------------------------------- output --
  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
    end else if (step) begin
      chars.valid <= 1'b1;
    end else if (chars.ready) begin
      chars.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      chars.ascii_char    <= char_val;
      chars.last_char     <= char_last;
      chars.address_error <= ctrl.err;
    end
  end

endmodule

// File: sv/ihexw_ucode_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode table
// One control word per step: the data record program, the end-of-file
// record program and the single address error step.
// ----------------------------------------------------------------------------
module ihexw_ucode_rom (
  input  logic [ihexw_pkg::PC_W-1:0] pc,
  output ihexw_pkg::ctrl_t           word
);
  import ihexw_pkg::*;

  always_comb begin
    case (pc)
      // Data record header.
      5'd0:  word = '{SRC_CONST,   1'b0, ":",   1'b0, FL_NEXT};
      5'd1:  word = '{SRC_COUNT,   1'b1, 8'h00, 1'b0, FL_NEXT};
      5'd2:  word = '{SRC_COUNT,   1'b0, 8'h00, 1'b0, FL_NEXT};
      5'd3:  word = '{SRC_ADDR_HI, 1'b1, 8'h00, 1'b0, FL_NEXT};
      5'd4:  word = '{SRC_ADDR_HI, 1'b0, 8'h00, 1'b0, FL_NEXT};
      5'd5:  word = '{SRC_ADDR_LO, 1'b1, 8'h00, 1'b0, FL_NEXT};
      5'd6:  word = '{SRC_ADDR_LO, 1'b0, 8'h00, 1'b0, FL_NEXT};
      5'd7:  word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd8:  word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      // Data bytes, looped over the buffer.
      5'd9:  word = '{SRC_DATA,    1'b1, 8'h00, 1'b0, FL_NEXT};
      5'd10: word = '{SRC_DATA,    1'b0, 8'h00, 1'b0, FL_DATA};
      // Checksum and line end.
      5'd11: word = '{SRC_SUM,     1'b1, 8'h00, 1'b0, FL_NEXT};
      5'd12: word = '{SRC_SUM,     1'b0, 8'h00, 1'b0, FL_NEXT};
      5'd13: word = '{SRC_CONST,   1'b0, 8'h0A, 1'b0, FL_REC_END};
      // End-of-file record.
      5'd14: word = '{SRC_CONST,   1'b0, ":",   1'b0, FL_NEXT};
      5'd15: word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd16: word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd17: word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd18: word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd19: word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd20: word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd21: word = '{SRC_CONST,   1'b0, "0",   1'b0, FL_NEXT};
      5'd22: word = '{SRC_CONST,   1'b0, "1",   1'b0, FL_NEXT};
      5'd23: word = '{SRC_CONST,   1'b0, "F",   1'b0, FL_NEXT};
      5'd24: word = '{SRC_CONST,   1'b0, "F",   1'b0, FL_NEXT};
      5'd25: word = '{SRC_CONST,   1'b0, 8'h0A, 1'b0, FL_DONE};
      // Address error marker.
      5'd26: word = '{SRC_CONST,   1'b0, 8'h00, 1'b1, FL_DONE};
      default: word = '{SRC_CONST, 1'b0, 8'h00, 1'b0, FL_DONE};
    endcase
  end

endmodule
